// ===== sv/psq_pkg.sv =====
`default_nettype none

package psq_pkg;

    // Default position of the binary point in pitch volts.
    localparam int FRACTION_BITS_DEF = 16;

    // Fixed field widths.
    localparam int PITCH_W     = 22;
    localparam int CV_W        = 22;
    localparam int OFFSET_W    = 18;
    localparam int MASK_W      = 12;
    localparam int GAIN_W      = 16;
    localparam int GAIN_FRAC   = 14;
    localparam int TUNE_W      = 48;
    localparam int CENT_W      = 8;
    localparam int OUT_W       = 24;
    localparam int CLASS_W     = 4;
    localparam int CFG_DATA_W  = 48;
    localparam int CFG_INDEX_W = 3;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 32;

    // Nearest-note table geometry.
    localparam int SEMITONES     = 12;
    localparam int TABLE_DEPTH   = 24;
    localparam int TABLE_IDX_W   = 5;
    localparam int NOTE_W        = 6;
    localparam int NOTES_PER_BANK = 6;

    // Cents arithmetic: one semitone is 100 cents, one octave is 1200 cents.
    // The division by 1200 is split into a shift by 4 and a division by 75.
    localparam int CENTS_PER_NOTE   = 100;
    localparam int CENTS_PER_OCTAVE = 1200;
    localparam int CENTS_SHIFT      = 4;
    localparam int RECIP_DIV        = CENTS_PER_OCTAVE >> CENTS_SHIFT;
    localparam int ROUND_BIAS       = (CENTS_PER_OCTAVE / 2) >> CENTS_SHIFT;
    localparam int TUNE_SUM_W       = 12;

    // Output saturation limits.
    localparam int OUT_MAX = (2 ** (OUT_W - 1)) - 1;
    localparam int OUT_MIN = -(2 ** (OUT_W - 1));

    // Register reset values.
    localparam logic [MASK_W-1:0] MASK_RESET = 12'hFFF;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_NOTE_MASK    = 3'd0,
        REG_SCALE_GAIN   = 3'd1,
        REG_OFFSET_VOLTS = 3'd2,
        REG_TUNE_LOW     = 3'd3,
        REG_TUNE_HIGH    = 3'd4
    } cfg_reg_t;

    typedef logic signed [NOTE_W-1:0] table_entry_t;

    // Folds a semitone in the range -12..23 into its class 0..11.
    function automatic logic [CLASS_W-1:0] wrap_class(input int n);
        if (n < 0) begin
            return CLASS_W'(n + SEMITONES);
        end else if (n >= SEMITONES) begin
            return CLASS_W'(n - SEMITONES);
        end
        return CLASS_W'(n);
    endfunction

    // Nearest enabled note to semitone (entry+1)/2. The lower note wins a tie,
    // and an empty mask enables every note. With at least one note enabled in
    // each octave the answer is never more than half an octave away.
    function automatic table_entry_t nearest_note(input logic [MASK_W-1:0] mask,
                                                  input int entry);
        logic [MASK_W-1:0] enabled;
        int                target;
        logic              found;
        table_entry_t      best;
        enabled = (mask == '0) ? '1 : mask;
        target  = (entry + 1) >> 1;
        found   = 1'b0;
        best    = NOTE_W'(target);
        for (int d = 0; d <= SEMITONES / 2; d++) begin
            if (!found && enabled[wrap_class(target - d)]) begin
                best  = NOTE_W'(target - d);
                found = 1'b1;
            end else if (!found && enabled[wrap_class(target + d)]) begin
                best  = NOTE_W'(target + d);
                found = 1'b1;
            end
        end
        return best;
    endfunction

endpackage

`default_nettype wire

// ===== sv/pitch_scale_quantizer_core.sv =====
// Pitch scale quantizer: snaps a 1 V/octave pitch to the enabled notes of a scale.
// Input items arrive on the s_ stream: pitch sample and offset CV, both signed volts.
// Result items leave on the m_ stream: quantized pitch with the note's microtune
// applied, and the chosen note's class within the octave (0 is C).
// Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_wr_data); a write to
// the note mask rebuilds the 24-entry nearest-note table in the same clock. Writes
// are expected only while the pipeline is empty.
// Throughput is one item per clock while the result stream is not stalled. There are
// eight register stages, the first loaded at the accepting edge. The sum, the gain
// multiply, the range scaling, the divide-by-3 reciprocal multiply, the table lookup,
// the cents sum, the divide-by-75 reciprocal multiply and the final correction with
// saturation each take one register stage.
// Each stage carries its own valid bit and loads whenever the stage after it can take
// its item, so bubbles close up. When m_tready is low the pipeline keeps accepting
// until all eight stages hold an item; only then does s_tready drop.
// Reset (aresetn low, synchronous) empties the pipeline and restores the configuration
// registers and note table: all notes enabled, unity gain, zero offset and zero microtune.
`default_nettype none

module pitch_scale_quantizer_core
    import psq_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // Input stream.
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [S_TDATA_W-1:0]   s_tdata,     // pitch_sample[21:0], offset_cv[43:22]
    // Result stream.
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [M_TDATA_W-1:0]        m_tdata,     // quantized_pitch[23:0], note_class[27:24]
    // Configuration writes.
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wr_data
);

    // Derived datapath widths.
    localparam int NSTAGE   = 8;
    localparam int SUM_W    = PITCH_W + 2;
    localparam int PROD_W   = SUM_W + GAIN_W + 1;
    localparam int P24_W    = PROD_W + 5;
    localparam int SHIFT    = FRACTION_BITS + GAIN_FRAC;
    localparam int RANGE_W  = P24_W - SHIFT;
    localparam int R3_W     = RANGE_W - 3;
    localparam int XB_W     = R3_W + 2;
    localparam int XBP_W    = 2 * XB_W;
    localparam int Q3_W     = XB_W - 1;
    localparam int OCT_W    = R3_W;
    localparam int O2_W     = OCT_W + 1;
    localparam int O2M_W    = O2_W + 1;
    localparam int Z_W      = TUNE_SUM_W + FRACTION_BITS - CENTS_SHIFT;
    localparam int ZP_W     = 2 * Z_W;
    localparam int Q75_W    = Z_W - 6;
    localparam int REM75_W  = 8;
    localparam int V_W      = O2_W + FRACTION_BITS + 2;

    // Bias that makes the range quotient non-negative before the divide by 3.
    localparam logic [XB_W-1:0]  BIAS3    = XB_W'(64'd3 << (R3_W - 1));
    localparam logic [Q3_W:0]    OCT_OFF  = (Q3_W + 1)'(64'd1 << (R3_W - 1));
    localparam logic [Q3_W-1:0]  RECIP3   = Q3_W'((64'd1 << XB_W) / 64'd3);
    localparam logic [Q75_W-1:0] RECIP75  = Q75_W'((64'd1 << Z_W) / 64'(RECIP_DIV));

    // ------------------------------------------------------------------
    // Configuration registers and nearest-note table.
    // ------------------------------------------------------------------
    logic [MASK_W-1:0]          note_mask_reg;
    logic [GAIN_W-1:0]          scale_gain_reg;
    logic signed [OFFSET_W-1:0] offset_volts_reg;
    logic [TUNE_W-1:0]          tune_low_reg;
    logic [TUNE_W-1:0]          tune_high_reg;
    table_entry_t               table_reg [TABLE_DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            note_mask_reg    <= MASK_RESET;
            scale_gain_reg   <= GAIN_RESET;
            offset_volts_reg <= '0;
            tune_low_reg     <= '0;
            tune_high_reg    <= '0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                table_reg[i] <= nearest_note(MASK_RESET, i);
            end
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_NOTE_MASK: begin
                    note_mask_reg <= cfg_wr_data[MASK_W-1:0];
                    for (int i = 0; i < TABLE_DEPTH; i++) begin
                        table_reg[i] <= nearest_note(cfg_wr_data[MASK_W-1:0], i);
                    end
                end
                REG_SCALE_GAIN:   scale_gain_reg   <= cfg_wr_data[GAIN_W-1:0];
                REG_OFFSET_VOLTS: offset_volts_reg <= $signed(cfg_wr_data[OFFSET_W-1:0]);
                REG_TUNE_LOW:     tune_low_reg     <= cfg_wr_data[TUNE_W-1:0];
                REG_TUNE_HIGH:    tune_high_reg    <= cfg_wr_data[TUNE_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage loads when it is empty or when the
    // stage after it loads.
    // ------------------------------------------------------------------
    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] stage_ready;

    always_comb begin
        stage_ready[NSTAGE-1] = !valid_reg[NSTAGE-1] || m_tready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_ready[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (stage_ready[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    assign s_tready = stage_ready[0];
    assign m_tvalid = valid_reg[NSTAGE-1];

    // ------------------------------------------------------------------
    // Stage 0: pitch plus offset CV plus offset register.
    // ------------------------------------------------------------------
    logic signed [PITCH_W-1:0] in_pitch;
    logic signed [CV_W-1:0]    in_cv;
    logic signed [SUM_W-1:0]   s0_sum_next;
    logic signed [SUM_W-1:0]   s0_sum_reg;

    assign in_pitch    = $signed(s_tdata[PITCH_W-1:0]);
    assign in_cv       = $signed(s_tdata[PITCH_W+CV_W-1:PITCH_W]);
    assign s0_sum_next = SUM_W'(in_pitch) + SUM_W'(in_cv) + SUM_W'(offset_volts_reg);

    always_ff @(posedge aclk) begin
        if (stage_ready[0]) begin
            s0_sum_reg <= s0_sum_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: gain multiply.
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] s1_prod_next;
    logic signed [PROD_W-1:0] s1_prod_reg;

    assign s1_prod_next = PROD_W'(s0_sum_reg) * PROD_W'($signed({1'b0, scale_gain_reg}));

    always_ff @(posedge aclk) begin
        if (stage_ready[1]) begin
            s1_prod_reg <= s1_prod_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: scale to 1/24-volt ranges and floor. The range is split
    // into its low three bits and a biased quotient by 8 that goes on
    // to the divide by 3.
    // ------------------------------------------------------------------
    logic signed [P24_W-1:0]   p24;
    logic signed [P24_W-1:0]   p24_shr;
    logic signed [RANGE_W-1:0] range_val;
    logic signed [R3_W-1:0]    r3;
    logic signed [XB_W-1:0]    r3_ext;
    logic [XB_W-1:0]           s2_xb_next;
    logic [XB_W-1:0]           s2_xb_reg;
    logic [2:0]                s2_low_reg;

    // Times 24 as times 16 plus times 8.
    assign p24        = (P24_W'(s1_prod_reg) <<< 4) + (P24_W'(s1_prod_reg) <<< 3);
    assign p24_shr    = p24 >>> SHIFT;
    assign range_val  = RANGE_W'(p24_shr);
    assign r3         = R3_W'(range_val >>> 3);
    assign r3_ext     = XB_W'(r3);
    assign s2_xb_next = $unsigned(r3_ext) + BIAS3;

    always_ff @(posedge aclk) begin
        if (stage_ready[2]) begin
            s2_xb_reg  <= s2_xb_next;
            s2_low_reg <= range_val[2:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: reciprocal multiply for the divide by 3; the estimate is
    // the true quotient or one below it.
    // ------------------------------------------------------------------
    logic [XBP_W-1:0] xb_prod;
    logic [Q3_W-1:0]  s3_q_reg;
    logic [XB_W-1:0]  s3_xb_reg;
    logic [2:0]       s3_low_reg;

    assign xb_prod = XBP_W'(s2_xb_reg) * XBP_W'(RECIP3);

    always_ff @(posedge aclk) begin
        if (stage_ready[3]) begin
            s3_q_reg   <= Q3_W'(xb_prod >> XB_W);
            s3_xb_reg  <= s2_xb_reg;
            s3_low_reg <= s2_low_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: correct the quotient, form octave and table index, look up
    // the nearest note and fold it into octave and class.
    // ------------------------------------------------------------------
    logic [XB_W-1:0]             q_times3;
    logic [XB_W-1:0]             rem3_full;
    logic [2:0]                  rem3;
    logic [2:0]                  rem3_fix;
    logic [Q3_W-1:0]             q3_fix;
    logic signed [Q3_W:0]        oct_wide;
    logic signed [OCT_W-1:0]     octave;
    logic [TABLE_IDX_W-1:0]      tbl_idx;
    table_entry_t                tbl_note;
    logic signed [2:0]           note_oct;
    logic signed [NOTE_W-1:0]    note_cls_wide;
    logic signed [O2_W-1:0]      s4_o2_next;
    logic signed [O2_W-1:0]      s4_o2_reg;
    logic [CLASS_W-1:0]          s4_cls_reg;

    assign q_times3  = XB_W'({s3_q_reg, 1'b0}) + XB_W'(s3_q_reg);
    assign rem3_full = s3_xb_reg - q_times3;
    assign rem3      = rem3_full[2:0];

    always_comb begin
        if (rem3 >= 3'd3) begin
            q3_fix   = s3_q_reg + Q3_W'(1);
            rem3_fix = rem3 - 3'd3;
        end else begin
            q3_fix   = s3_q_reg;
            rem3_fix = rem3;
        end
    end

    assign oct_wide = $signed({1'b0, q3_fix}) - $signed(OCT_OFF);
    assign octave   = OCT_W'(oct_wide);
    assign tbl_idx  = {rem3_fix[1:0], s3_low_reg};
    assign tbl_note = table_reg[tbl_idx];

    // Table notes lie within one octave either side; fold into the octave.
    always_comb begin
        if (tbl_note < 0) begin
            note_oct      = -3'sd1;
            note_cls_wide = tbl_note + NOTE_W'(SEMITONES);
        end else if (tbl_note < NOTE_W'(SEMITONES)) begin
            note_oct      = 3'sd0;
            note_cls_wide = tbl_note;
        end else if (tbl_note < NOTE_W'(2 * SEMITONES)) begin
            note_oct      = 3'sd1;
            note_cls_wide = tbl_note - NOTE_W'(SEMITONES);
        end else begin
            note_oct      = 3'sd2;
            note_cls_wide = tbl_note - NOTE_W'(2 * SEMITONES);
        end
    end

    assign s4_o2_next = O2_W'(octave) + O2_W'(note_oct);

    always_ff @(posedge aclk) begin
        if (stage_ready[4]) begin
            s4_o2_reg  <= s4_o2_next;
            s4_cls_reg <= CLASS_W'(note_cls_wide);
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: microtune lookup and the cents value within the octave.
    // One octave is added so the value stays positive; the octave count
    // is lowered by one to match.
    // ------------------------------------------------------------------
    logic                      use_low_bank;
    logic [TUNE_W-1:0]         tune_bank;
    logic [2:0]                tune_sel;
    logic [CENT_W-1:0]         cents;
    logic [TUNE_SUM_W-1:0]     cents_total;
    logic [Z_W-1:0]            s5_z_next;
    logic [Z_W-1:0]            s5_z_reg;
    logic signed [O2M_W-1:0]   s5_o2m1_reg;
    logic [CLASS_W-1:0]        s5_cls_reg;

    assign use_low_bank = s4_cls_reg < CLASS_W'(NOTES_PER_BANK);
    assign tune_bank    = use_low_bank ? tune_low_reg : tune_high_reg;
    assign tune_sel     = use_low_bank ? s4_cls_reg[2:0]
                                       : 3'(s4_cls_reg - CLASS_W'(NOTES_PER_BANK));
    assign cents        = tune_bank[{tune_sel, 3'b000} +: CENT_W];
    assign cents_total  = TUNE_SUM_W'(s4_cls_reg) * TUNE_SUM_W'(CENTS_PER_NOTE)
                        + {{(TUNE_SUM_W - CENT_W){cents[CENT_W-1]}}, cents}
                        + TUNE_SUM_W'(CENTS_PER_OCTAVE);
    assign s5_z_next    = (Z_W'(cents_total) << (FRACTION_BITS - CENTS_SHIFT))
                        + Z_W'(ROUND_BIAS);

    always_ff @(posedge aclk) begin
        if (stage_ready[5]) begin
            s5_z_reg    <= s5_z_next;
            s5_o2m1_reg <= O2M_W'(s4_o2_reg) - O2M_W'(1);
            s5_cls_reg  <= s4_cls_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: reciprocal multiply for the divide by 75.
    // ------------------------------------------------------------------
    logic [ZP_W-1:0]         z_prod;
    logic [Q75_W-1:0]        s6_q_reg;
    logic [Z_W-1:0]          s6_z_reg;
    logic signed [O2M_W-1:0] s6_o2m1_reg;
    logic [CLASS_W-1:0]      s6_cls_reg;

    assign z_prod = ZP_W'(s5_z_reg) * ZP_W'(RECIP75);

    always_ff @(posedge aclk) begin
        if (stage_ready[6]) begin
            s6_q_reg    <= Q75_W'(z_prod >> Z_W);
            s6_z_reg    <= s5_z_reg;
            s6_o2m1_reg <= s5_o2m1_reg;
            s6_cls_reg  <= s5_cls_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: quotient correction, octave recombination and saturation.
    // ------------------------------------------------------------------
    logic [Z_W-1:0]          rem75_full;
    logic [REM75_W-1:0]      rem75;
    logic [Q75_W-1:0]        q75_fix;
    logic signed [V_W-1:0]   v_base;
    logic signed [V_W-1:0]   v_frac;
    logic signed [V_W-1:0]   v_sum;
    logic signed [OUT_W-1:0] s7_pitch_next;
    logic signed [OUT_W-1:0] s7_pitch_reg;
    logic [CLASS_W-1:0]      s7_cls_reg;

    assign rem75_full = s6_z_reg - Z_W'(s6_q_reg) * Z_W'(RECIP_DIV);
    assign rem75      = REM75_W'(rem75_full);
    assign q75_fix    = (rem75 >= REM75_W'(RECIP_DIV)) ? s6_q_reg + Q75_W'(1) : s6_q_reg;
    assign v_base     = V_W'(s6_o2m1_reg) <<< FRACTION_BITS;
    assign v_frac     = $signed(V_W'(q75_fix));
    assign v_sum      = v_base + v_frac;

    always_comb begin
        if (v_sum > V_W'(OUT_MAX)) begin
            s7_pitch_next = OUT_W'(OUT_MAX);
        end else if (v_sum < V_W'(OUT_MIN)) begin
            s7_pitch_next = OUT_W'(OUT_MIN);
        end else begin
            s7_pitch_next = OUT_W'(v_sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[7]) begin
            s7_pitch_reg <= s7_pitch_next;
            s7_cls_reg   <= s6_cls_reg;
        end
    end

    assign m_tdata = {(M_TDATA_W - OUT_W - CLASS_W)'(0), s7_cls_reg, s7_pitch_reg};

endmodule

`default_nettype wire

// ===== sv/psq_checker.sv =====
`default_nettype none

module psq_checker
    import psq_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    // A waiting result item stays offered.
    a_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item withdrawn while stalled");

    // A waiting result item keeps its value.
    a_data_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result item changed while stalled");

    // With the output stage empty, every stage can move, so input is taken.
    a_empty_out_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while the output stage is empty");

    // The note class is always a semitone within the octave.
    a_class_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[OUT_W +: CLASS_W] <= CLASS_W'(SEMITONES - 1))
        else $error("note class out of range");

endmodule

bind pitch_scale_quantizer_core psq_checker u_psq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
